>>> src/dra_pkg.sv
// DNS reply address parser: shared types and constants.
// No dependencies; dra_parser, dra_out_queue and the top level refer to this package.
package dra_pkg;

	// Parse phases, one-hot
	typedef enum logic [13:0] {
		PH_HEADER = 14'b00000000000001,
		PH_QNAME  = 14'b00000000000010,
		PH_QLABEL = 14'b00000000000100,
		PH_QPTR   = 14'b00000000001000,
		PH_QFIXED = 14'b00000000010000,
		PH_ANAME  = 14'b00000000100000,
		PH_ALABEL = 14'b00000001000000,
		PH_APTR   = 14'b00000010000000,
		PH_AFIXED = 14'b00000100000000,
		PH_ATTL   = 14'b00001000000000,
		PH_ALEN   = 14'b00010000000000,
		PH_AADDR  = 14'b00100000000000,
		PH_DONE   = 14'b01000000000000,
		PH_HALT   = 14'b10000000000000
	} phase_t;

	typedef logic [2:0] status_t;

	localparam status_t ST_OK        = 3'd0;
	localparam status_t ST_SHORT     = 3'd1;
	localparam status_t ST_ID        = 3'd2;
	localparam status_t ST_NOT_RESP  = 3'd3;
	localparam status_t ST_OPCODE    = 3'd4;
	localparam status_t ST_TRUNC     = 3'd5;
	localparam status_t ST_RCODE     = 3'd6;
	localparam status_t ST_BAD_LEN   = 3'd7;

	localparam logic KIND_ADDR   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam logic [3:0]  HDR_LAST_POS = 4'd11;
	localparam logic [7:0]  PTR_MARK     = 8'hC0;
	localparam logic [15:0] ADDR_LEN     = 16'd4;
	localparam logic [1:0]  FIELD_LAST4  = 2'd3;

	typedef struct packed {
		logic        result_kind;
		logic [31:0] ttl_seconds;
		logic [31:0] ipv4_address;
		status_t     status;
		logic [3:0]  response_code;
		logic        end_of_run;
	} result_t;

	// Results raised by one accepted byte: address record first, then status
	typedef struct packed {
		logic    rec_vld;
		logic    stat_vld;
		result_t rec;
		result_t stat;
	} push_t;

endpackage

>>> src/dra_byte_if.sv
// Byte channel into the DNS reply parser: valid/ready plus one packet byte.
// No dependencies.
interface dra_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] packet_byte;
	logic       last_byte;

	modport source (output valid, output packet_byte, output last_byte, input ready);
	modport sink   (input valid, input packet_byte, input last_byte, output ready);
endinterface

>>> src/dra_result_if.sv
// Result channel out of the DNS reply parser: valid/ready plus one result.
// No dependencies.
interface dra_result_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [31:0] ttl_seconds;
	logic [31:0] ipv4_address;
	logic [2:0]  status;
	logic [3:0]  response_code;
	logic        end_of_run;

	modport source (output valid, output result_kind, output ttl_seconds,
		output ipv4_address, output status, output response_code,
		output end_of_run, input ready);
	modport sink   (input valid, input result_kind, input ttl_seconds,
		input ipv4_address, input status, input response_code,
		input end_of_run, output ready);
endinterface

>>> src/dra_parser.sv
// Byte-wise DNS reply parse state machine; one accepted beat per cycle while fire is high.
// Depends on dra_pkg.
module dra_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  logic [7:0]       packet_byte,
	input  logic             last_byte,
	input  logic [15:0]      expected_id,
	output dra_pkg::push_t   push
);

	dra_pkg::phase_t    phase_q, phase_d;
	logic [3:0]         hpos_q, hpos_d;
	dra_pkg::status_t   err_q, err_d;
	logic [15:0]        rid_q, rid_d;
	logic [15:0]        flags_q, flags_d;
	logic [15:0]        qleft_q, qleft_d;
	logic [15:0]        aleft_q, aleft_d;
	logic [7:0]         skip_q, skip_d;
	logic [1:0]         idx_q, idx_d;
	logic [31:0]        ttl_q, ttl_d;
	logic [7:0]         lenhi_q, lenhi_d;
	logic [23:0]        addr_q, addr_d;
	dra_pkg::status_t   hdr_st;
	dra_pkg::status_t   end_st;
	logic               is_q;

	// Header verdict, earliest failing check wins
	always_comb begin
		if (rid_q != expected_id) begin
			hdr_st = dra_pkg::ST_ID;
		end else if (!flags_q[15]) begin
			hdr_st = dra_pkg::ST_NOT_RESP;
		end else if (flags_q[14:11] != 4'd0) begin
			hdr_st = dra_pkg::ST_OPCODE;
		end else if (flags_q[9]) begin
			hdr_st = dra_pkg::ST_TRUNC;
		end else if (flags_q[3:0] != 4'd0) begin
			hdr_st = dra_pkg::ST_RCODE;
		end else begin
			hdr_st = dra_pkg::ST_OK;
		end
	end

	always_comb begin
		phase_d = phase_q;
		hpos_d  = hpos_q;
		err_d   = err_q;
		rid_d   = rid_q;
		flags_d = flags_q;
		qleft_d = qleft_q;
		aleft_d = aleft_q;
		skip_d  = skip_q;
		idx_d   = idx_q;
		ttl_d   = ttl_q;
		lenhi_d = lenhi_q;
		addr_d  = addr_q;
		is_q    = 1'b0;
		push    = '0;

		case (phase_q)
			dra_pkg::PH_HEADER: begin
				case (hpos_q)
					4'd0: rid_d = {packet_byte, 8'h00};
					4'd1: rid_d = {rid_q[15:8], packet_byte};
					4'd2: flags_d = {packet_byte, 8'h00};
					4'd3: flags_d = {flags_q[15:8], packet_byte};
					4'd4: qleft_d = {packet_byte, 8'h00};
					4'd5: qleft_d = {qleft_q[15:8], packet_byte};
					4'd6: aleft_d = {packet_byte, 8'h00};
					4'd7: aleft_d = {aleft_q[15:8], packet_byte};
					default: ;
				endcase
				hpos_d = hpos_q + 4'd1;
				if (hpos_q == dra_pkg::HDR_LAST_POS) begin
					err_d = hdr_st;
					if (hdr_st != dra_pkg::ST_OK) begin
						phase_d = dra_pkg::PH_HALT;
					end else if (qleft_q != 16'd0) begin
						phase_d = dra_pkg::PH_QNAME;
					end else if (aleft_q != 16'd0) begin
						phase_d = dra_pkg::PH_ANAME;
					end else begin
						phase_d = dra_pkg::PH_DONE;
					end
				end
			end
			dra_pkg::PH_QNAME, dra_pkg::PH_ANAME: begin
				is_q = (phase_q == dra_pkg::PH_QNAME);
				if (packet_byte == 8'd0) begin
					idx_d   = 2'd0;
					phase_d = is_q ? dra_pkg::PH_QFIXED : dra_pkg::PH_AFIXED;
				end else if ((packet_byte & dra_pkg::PTR_MARK) == dra_pkg::PTR_MARK) begin
					phase_d = is_q ? dra_pkg::PH_QPTR : dra_pkg::PH_APTR;
				end else begin
					skip_d  = packet_byte;
					phase_d = is_q ? dra_pkg::PH_QLABEL : dra_pkg::PH_ALABEL;
				end
			end
			dra_pkg::PH_QLABEL, dra_pkg::PH_ALABEL: begin
				is_q   = (phase_q == dra_pkg::PH_QLABEL);
				skip_d = skip_q - 8'd1;
				if (skip_q == 8'd1) begin
					phase_d = is_q ? dra_pkg::PH_QNAME : dra_pkg::PH_ANAME;
				end
			end
			dra_pkg::PH_QPTR, dra_pkg::PH_APTR: begin
				is_q    = (phase_q == dra_pkg::PH_QPTR);
				idx_d   = 2'd0;
				phase_d = is_q ? dra_pkg::PH_QFIXED : dra_pkg::PH_AFIXED;
			end
			dra_pkg::PH_QFIXED: begin
				idx_d = idx_q + 2'd1;
				if (idx_q == dra_pkg::FIELD_LAST4) begin
					qleft_d = qleft_q - 16'd1;
					if (qleft_q != 16'd1) begin
						phase_d = dra_pkg::PH_QNAME;
					end else if (aleft_q != 16'd0) begin
						phase_d = dra_pkg::PH_ANAME;
					end else begin
						phase_d = dra_pkg::PH_DONE;
					end
				end
			end
			dra_pkg::PH_AFIXED: begin
				idx_d = idx_q + 2'd1;
				if (idx_q == dra_pkg::FIELD_LAST4) begin
					phase_d = dra_pkg::PH_ATTL;
				end
			end
			dra_pkg::PH_ATTL: begin
				ttl_d = {ttl_q[23:0], packet_byte};
				idx_d = idx_q + 2'd1;
				if (idx_q == dra_pkg::FIELD_LAST4) begin
					phase_d = dra_pkg::PH_ALEN;
				end
			end
			dra_pkg::PH_ALEN: begin
				if (idx_q == 2'd0) begin
					lenhi_d = packet_byte;
					idx_d   = 2'd1;
				end else begin
					idx_d = 2'd0;
					if ({lenhi_q, packet_byte} != dra_pkg::ADDR_LEN) begin
						err_d   = dra_pkg::ST_BAD_LEN;
						phase_d = dra_pkg::PH_HALT;
					end else begin
						phase_d = dra_pkg::PH_AADDR;
					end
				end
			end
			dra_pkg::PH_AADDR: begin
				addr_d = {addr_q[15:0], packet_byte};
				idx_d  = idx_q + 2'd1;
				if (idx_q == dra_pkg::FIELD_LAST4) begin
					push.rec_vld              = fire;
					push.rec.result_kind      = dra_pkg::KIND_ADDR;
					push.rec.ttl_seconds      = ttl_q;
					push.rec.ipv4_address     = {addr_q, packet_byte};
					push.rec.status           = dra_pkg::ST_OK;
					push.rec.response_code    = 4'd0;
					push.rec.end_of_run       = !last_byte;
					aleft_d = aleft_q - 16'd1;
					phase_d = (aleft_q != 16'd1) ? dra_pkg::PH_ANAME : dra_pkg::PH_DONE;
				end
			end
			default: ;
		endcase

		// End-of-packet status reflects the state after this beat
		if (phase_d == dra_pkg::PH_HALT) begin
			end_st = err_d;
		end else if (phase_d == dra_pkg::PH_DONE) begin
			end_st = dra_pkg::ST_OK;
		end else begin
			end_st = dra_pkg::ST_SHORT;
		end
		push.stat_vld              = fire && last_byte;
		push.stat.result_kind      = dra_pkg::KIND_STATUS;
		push.stat.ttl_seconds      = 32'd0;
		push.stat.ipv4_address     = 32'd0;
		push.stat.status           = end_st;
		push.stat.response_code    = (end_st == dra_pkg::ST_RCODE) ? flags_d[3:0] : 4'd0;
		push.stat.end_of_run       = 1'b1;
	end

	// Control state; cleared after the final beat of a packet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= dra_pkg::PH_HEADER;
			hpos_q  <= 4'd0;
			err_q   <= dra_pkg::ST_OK;
		end else if (fire) begin
			if (last_byte) begin
				phase_q <= dra_pkg::PH_HEADER;
				hpos_q  <= 4'd0;
				err_q   <= dra_pkg::ST_OK;
			end else begin
				phase_q <= phase_d;
				hpos_q  <= hpos_d;
				err_q   <= err_d;
			end
		end
	end

	// Gathered fields; each is rewritten before it is read
	always_ff @(posedge clk) begin
		if (fire) begin
			rid_q   <= rid_d;
			flags_q <= flags_d;
			qleft_q <= qleft_d;
			aleft_q <= aleft_d;
			skip_q  <= skip_d;
			idx_q   <= idx_d;
			ttl_q   <= ttl_d;
			lenhi_q <= lenhi_d;
			addr_q  <= addr_d;
		end
	end

endmodule

>>> src/dra_out_queue.sv
// Result queue: takes up to two results per cycle, hands out one per beat.
// Depends on dra_pkg.
module dra_out_queue #(
	parameter int DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dra_pkg::push_t    push,
	input  logic              pop,
	output logic              has_room,
	output logic              not_empty,
	output dra_pkg::result_t  head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
	localparam logic [CW-1:0] ROOM_MAX  = CW'(DEPTH - 2);

	dra_pkg::result_t   slot_q [DEPTH];
	logic [PW-1:0]      wp_q, rp_q, wp_nx;
	logic [CW-1:0]      cnt_q;
	logic [1:0]         n_push;
	dra_pkg::result_t   first;

	assign wp_nx     = (wp_q == LAST_SLOT) ? '0 : wp_q + PW'(1);
	assign n_push    = {1'b0, push.rec_vld} + {1'b0, push.stat_vld};
	assign first     = push.rec_vld ? push.rec : push.stat;
	assign not_empty = (cnt_q != '0);
	assign has_room  = (cnt_q <= ROOM_MAX);
	assign head      = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			slot_q[wp_q] <= first;
		end
		if (n_push == 2'd2) begin
			slot_q[wp_nx] <= push.stat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			case (n_push)
				2'd1:    wp_q <= wp_nx;
				2'd2:    wp_q <= (wp_nx == LAST_SLOT) ? '0 : wp_nx + PW'(1);
				default: ;
			endcase
			if (pop) begin
				rp_q <= (rp_q == LAST_SLOT) ? '0 : rp_q + PW'(1);
			end
			cnt_q <= cnt_q + CW'(n_push) - CW'(pop);
		end
	end

endmodule

>>> src/dns_reply_address_parser_unit.sv
// DNS reply address parser, top level: byte sink, result source, ID register.
// Depends on dra_pkg, dra_byte_if, dra_result_if, dra_parser, dra_out_queue.
//
//  channel   dir  beat carries                                  handshake
//  --------  ---  --------------------------------------------  ------------
//  pkt       in   packet_byte, last_byte                        valid/ready
//  rsp       out  result_kind, ttl_seconds, ipv4_address,       valid/ready
//                 status, response_code, end_of_run
//  cfg       in   cfg_wr_data (expected_id)                     cfg_wr_en
//
// One byte per cycle: a byte beat is parsed in the cycle it is accepted and its
// results (address record, end-of-packet status, or both) enter the result queue
// at that edge, so the first result can leave in the cycle after its byte.
// pkt.ready is high while the queue has room for two more results; with rsp always
// ready it never drops. Reset puts the parser in the header phase, empties the
// queue and zeroes expected_id. A stall on rsp backs up the queue, then pkt.
module dns_reply_address_parser_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	dra_byte_if.sink      pkt,
	dra_result_if.source  rsp,
	input  logic          cfg_wr_en,
	input  logic [15:0]   cfg_wr_data
);

	logic [15:0]        expected_id_q;
	logic               in_fire;
	logic               out_fire;
	logic               has_room;
	logic               not_empty;
	dra_pkg::push_t     push;
	dra_pkg::result_t   head;

	// Expected query ID; the user must write it only while no packet is in flight (not enforced here)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_id_q <= 16'd0;
		end else if (cfg_wr_en) begin
			expected_id_q <= cfg_wr_data;
		end
	end

	assign pkt.ready = has_room;
	assign in_fire   = pkt.valid && has_room;
	assign out_fire  = not_empty && rsp.ready;

	dra_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (in_fire),
		.packet_byte (pkt.packet_byte),
		.last_byte   (pkt.last_byte),
		.expected_id (expected_id_q),
		.push        (push)
	);

	dra_out_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (out_fire),
		.has_room  (has_room),
		.not_empty (not_empty),
		.head      (head)
	);

	// Result beat straight from the queue head
	assign rsp.valid         = not_empty;
	assign rsp.result_kind   = head.result_kind;
	assign rsp.ttl_seconds   = head.ttl_seconds;
	assign rsp.ipv4_address  = head.ipv4_address;
	assign rsp.status        = head.status;
	assign rsp.response_code = head.response_code;
	assign rsp.end_of_run    = head.end_of_run;

endmodule
